// ===== rtl/ppdp_pkg.sv =====
`default_nettype none
package ppdp_pkg;

    localparam int DEF_SCREEN_W = 160;
    localparam int DEF_SCREEN_H = 44;

    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic signed [40:0] NEAR_LIMIT = 41'sd102;

    // Outcome codes of a result beat.
    localparam logic [2:0] OUT_WRITTEN = 3'd0;
    localparam logic [2:0] OUT_NEAR    = 3'd1;
    localparam logic [2:0] OUT_OFFSCR  = 3'd2;
    localparam logic [2:0] OUT_HIDDEN  = 3'd3;
    localparam logic [2:0] OUT_READ    = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_CAMERA_X     = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
    localparam logic [2:0] REG_CAMERA_Z     = 3'd2;
    localparam logic [2:0] REG_SINE_YAW     = 3'd3;
    localparam logic [2:0] REG_COSINE_YAW   = 3'd4;
    localparam logic [2:0] REG_SINE_PITCH   = 3'd5;
    localparam logic [2:0] REG_COSINE_PITCH = 3'd6;
    localparam logic [2:0] REG_FOCAL_GAIN   = 3'd7;

    typedef struct packed {
        logic               mode;
        logic signed [19:0] world_x;
        logic signed [19:0] world_y;
        logic signed [19:0] world_z;
        logic [7:0]         glyph_in;
        logic [12:0]        pixel_index;
    } t_in;

    typedef struct packed {
        logic [2:0] outcome;
        logic [7:0] glyph_out;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_SUB,
        S_RX0, S_RX1, S_RZ0, S_RZ1, S_RY0, S_RY1, S_CZ0, S_CZ1,
        S_DIV, S_QX, S_QY, S_VX, S_VY, S_PIX, S_CMP,
        S_RDM, S_RDC, S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/point_project_depth_plot_core.sv =====
`default_nettype none
// Perspective point plotter with a per-pixel inverse-depth buffer.
// Input channel (i_in_valid / o_in_stall, payload i_in) carries one beat per
// item: mode 0 plots a world point with a glyph, mode 1 reads one pixel's
// glyph and clears that pixel. Output channel (o_out_valid / i_out_stall,
// payload o_out) returns one beat per item with the outcome and glyph.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) sets the
// camera position, yaw and pitch sine and cosine and the focal gain; write it
// only while no item is in flight.
// A plot beat runs from acceptance to its result register through one
// subtract, the rotation steps on the shared rotation multiplier, the
// bit-serial inverse-depth divider, four projection multiplies, the address
// step, the depth read-modify-write and the output load. An off-screen point
// ends after the address step, a point behind the near plane after the
// rotation, and a read beat outside the screen skips the memory read. One
// item is worked on at a time; the next one is taken the cycle after the
// result is loaded.
// The result sits in an output register, so the next item is taken while a
// stalled result waits; the block only holds at its final step when the
// output register is still full and stalled.
// After reset the block sweeps both pixel memories, one entry per cycle,
// through all SCREEN_W * SCREEN_H entries (7040 by default), stalling input.
module point_project_depth_plot_core #(
    parameter int SCREEN_W = ppdp_pkg::DEF_SCREEN_W,
    parameter int SCREEN_H = ppdp_pkg::DEF_SCREEN_H
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ppdp_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ppdp_pkg::t_out     o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [19:0]   i_cfg_data
);
    import ppdp_pkg::*;

    localparam int PIX = SCREEN_W * SCREEN_H;
    localparam int AW  = $clog2(PIX);

    // Configuration.
    logic signed [19:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [15:0] r_sin_yaw, r_cos_yaw, r_sin_pitch, r_cos_pitch;
    logic [15:0]        r_focal;

    // Control.
    t_state     r_state, n_state;
    logic       r_clearing;
    logic [AW-1:0] r_clr_cnt;
    logic       r_out_valid;
    t_out       r_out;
    t_in        r_item;
    logic [2:0] r_res_outcome, n_res_outcome;
    logic [7:0] r_res_glyph, n_res_glyph;
    logic [4:0] r_cnt;
    logic       in_acc, out_load;

    // Datapath.
    logic signed [20:0] r_cx, r_cy, r_cz;
    logic signed [40:0] r_t;
    logic signed [23:0] r_rx, r_rz;
    logic signed [26:0] r_ry, r_czr;
    logic [28:0]        r_rem;
    logic [23:0]        r_quo;
    logic signed [31:0] r_qx;
    logic signed [35:0] r_qy;
    logic signed [55:0] r_vx, r_vy;
    logic [AW-1:0]      r_idx;

    // Memories.
    logic [23:0] depth_mem [PIX];
    logic [7:0]  glyph_mem [PIX];
    logic [23:0] r_depth_rd;
    logic [7:0]  r_glyph_rd;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0]   mem_wdepth;
    logic [7:0]    mem_wglyph;

    // Shared rotation multiplier.
    logic signed [23:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [40:0] mul_p, rot_sum, rot_sh;
    // Divider step.
    logic [28:0] rem_sh, rem_diff;
    logic        div_ge;
    // Projection.
    logic signed [16:0] gain_s;
    logic signed [24:0] ooz_s;
    logic signed [48:0] px_prod;
    logic signed [51:0] py_prod;
    logic signed [48:0] gx_prod;
    logic signed [52:0] gy_prod;
    logic signed [55:0] col_t, row_t;
    logic               on_screen;
    logic [15:0]        idx_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || r_clearing;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_RX0: begin mul_a = 24'(r_cx); mul_b = r_cos_yaw; end
            S_RX1: begin mul_a = 24'(r_cz); mul_b = r_sin_yaw; end
            S_RZ0: begin mul_a = 24'(r_cz); mul_b = r_cos_yaw; end
            S_RZ1: begin mul_a = 24'(r_cx); mul_b = r_sin_yaw; end
            S_RY0: begin mul_a = 24'(r_cy); mul_b = r_cos_pitch; end
            S_RY1: begin mul_a = r_rz;      mul_b = r_sin_pitch; end
            S_CZ0: begin mul_a = 24'(r_cy); mul_b = r_sin_pitch; end
            S_CZ1: begin mul_a = r_rz;      mul_b = r_cos_pitch; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
        if (r_state == S_RZ1 || r_state == S_RY1) begin
            rot_sum = r_t - mul_p;
        end else begin
            rot_sum = r_t + mul_p;
        end
        // Arithmetic shift is floor division by 2^14.
        rot_sh = rot_sum >>> 14;
    end

    // Restoring divider for 2^30 / depth, one quotient bit per cycle.
    assign rem_sh   = {r_rem[27:0], (r_cnt == 5'd30)};
    assign rem_diff = rem_sh - {2'b00, r_czr};
    assign div_ge   = !rem_diff[28];

    assign gain_s  = signed'({1'b0, r_focal});
    assign ooz_s   = signed'({1'b0, r_quo});
    assign px_prod = r_rx * ooz_s;
    assign py_prod = r_ry * ooz_s;
    assign gx_prod = gain_s * r_qx;
    assign gy_prod = gain_s * r_qy;

    // Truncation toward zero: negative values are biased before the shift.
    always_comb begin
        if (r_vx < 0) begin
            col_t = (r_vx + 56'sd4194303) >>> 22;
        end else begin
            col_t = r_vx >>> 22;
        end
        if (r_vy < 0) begin
            row_t = (r_vy + 56'sd4194303) >>> 22;
        end else begin
            row_t = r_vy >>> 22;
        end
        on_screen = (col_t >= 0) && (col_t < 56'(SCREEN_W))
                 && (row_t >= 0) && (row_t < 56'(SCREEN_H));
        idx_full  = 16'(row_t) * 16'(SCREEN_W) + 16'(col_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_res_outcome = r_res_outcome;
        n_res_glyph   = r_res_glyph;
        mem_re        = 1'b0;
        mem_raddr     = r_idx;
        mem_we        = 1'b0;
        mem_waddr     = r_idx;
        mem_wdepth    = '0;
        mem_wglyph    = SPACE_CODE;
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_in.mode ? S_RDM : S_SUB;
                end
            end
            S_SUB: n_state = S_RX0;
            S_RX0: n_state = S_RX1;
            S_RX1: n_state = S_RZ0;
            S_RZ0: n_state = S_RZ1;
            S_RZ1: n_state = S_RY0;
            S_RY0: n_state = S_RY1;
            S_RY1: n_state = S_CZ0;
            S_CZ0: n_state = S_CZ1;
            S_CZ1: begin
                if (rot_sh <= NEAR_LIMIT) begin
                    n_res_outcome = OUT_NEAR;
                    n_res_glyph   = '0;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == 5'd0) begin
                    n_state = S_QX;
                end
            end
            S_QX: n_state = S_QY;
            S_QY: n_state = S_VX;
            S_VX: n_state = S_VY;
            S_VY: n_state = S_PIX;
            S_PIX: begin
                if (on_screen) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_full);
                    n_state   = S_CMP;
                end else begin
                    n_res_outcome = OUT_OFFSCR;
                    n_res_glyph   = '0;
                    n_state       = S_OUT;
                end
            end
            S_CMP: begin
                n_res_glyph = '0;
                if (r_quo > r_depth_rd) begin
                    mem_we        = 1'b1;
                    mem_wdepth    = r_quo;
                    mem_wglyph    = r_item.glyph_in;
                    n_res_outcome = OUT_WRITTEN;
                end else begin
                    n_res_outcome = OUT_HIDDEN;
                end
                n_state = S_OUT;
            end
            S_RDM: begin
                n_res_outcome = OUT_READ;
                n_res_glyph   = '0;
                if (16'(r_item.pixel_index) < 16'(PIX)) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_item.pixel_index);
                    n_state   = S_RDC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RDC: begin
                n_res_glyph = r_glyph_rd;
                mem_we      = 1'b1;
                mem_waddr   = AW'(r_item.pixel_index);
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            depth_mem[mem_waddr] <= mem_wdepth;
            glyph_mem[mem_waddr] <= mem_wglyph;
        end
        if (mem_re) begin
            r_depth_rd <= depth_mem[mem_raddr];
            r_glyph_rd <= glyph_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_cam_z     <= '0;
            r_sin_yaw   <= '0;
            r_cos_yaw   <= 16'sd16384;
            r_sin_pitch <= '0;
            r_cos_pitch <= 16'sd16384;
            r_focal     <= 16'd12800;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(PIX - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_CAMERA_X:     r_cam_x     <= i_cfg_data;
                    REG_CAMERA_Y:     r_cam_y     <= i_cfg_data;
                    REG_CAMERA_Z:     r_cam_z     <= i_cfg_data;
                    REG_SINE_YAW:     r_sin_yaw   <= i_cfg_data[15:0];
                    REG_COSINE_YAW:   r_cos_yaw   <= i_cfg_data[15:0];
                    REG_SINE_PITCH:   r_sin_pitch <= i_cfg_data[15:0];
                    REG_COSINE_PITCH: r_cos_pitch <= i_cfg_data[15:0];
                    REG_FOCAL_GAIN:   r_focal     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_outcome <= n_res_outcome;
        r_res_glyph   <= n_res_glyph;
        if (out_load) begin
            r_out.outcome   <= r_res_outcome;
            r_out.glyph_out <= r_res_glyph;
        end
        if (in_acc) begin
            r_item <= i_in;
        end
        case (r_state)
            S_SUB: begin
                r_cx <= 21'(r_item.world_x) - 21'(r_cam_x);
                r_cy <= 21'(r_item.world_y) - 21'(r_cam_y);
                r_cz <= 21'(r_item.world_z) - 21'(r_cam_z);
            end
            S_RX0, S_RZ0, S_RY0, S_CZ0: r_t <= mul_p;
            S_RX1: r_rx <= 24'(rot_sh);
            S_RZ1: r_rz <= 24'(rot_sh);
            S_RY1: r_ry <= 27'(rot_sh);
            S_CZ1: begin
                r_czr <= 27'(rot_sh);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 5'd30;
            end
            S_DIV: begin
                r_rem <= div_ge ? rem_diff : rem_sh;
                r_quo <= {r_quo[22:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_QX: r_qx <= 32'(px_prod >>> 16);
            S_QY: r_qy <= 36'(py_prod >>> 16);
            S_VX: r_vx <= (56'(SCREEN_W) <<< 21) + (56'(gx_prod) <<< 1);
            S_VY: r_vy <= (56'(SCREEN_H) <<< 21) - 56'(gy_prod);
            S_PIX: r_idx <= AW'(idx_full);
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/ppdp_checker.sv =====
`default_nettype none
module ppdp_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire ppdp_pkg::t_out o_out
);
    import ppdp_pkg::*;

    // Outcome codes stop at the read code.
    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.outcome <= OUT_READ))
        else $error("outcome code out of range");

    // Only a read beat carries a glyph.
    a_plot_glyph_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.outcome != OUT_READ)) |-> (o_out.glyph_out == 8'd0))
        else $error("plot result with nonzero glyph");

    // The memory sweep after reset holds off input.
    a_reset_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (o_in_stall && !o_out_valid))
        else $error("input taken or result shown right after reset");

    // A stalled result beat is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result beat changed");

endmodule

bind point_project_depth_plot_core ppdp_checker u_ppdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
`default_nettype wire
